// ===== src/tuart_pkg.sv =====
// Shared types and constants for the tick-timed 8N1 UART transceiver.
package tuart_pkg;

    // Frame layout: one start bit, DataBits data bits, one stop bit.
    localparam int DataBits    = 8;
    localparam int FrameBits   = DataBits + 2;
    localparam int BitCntW     = $clog2(FrameBits + 1);

    // Widths of the configuration registers.
    localparam int BitPeriodW  = 16;
    localparam int HalfPeriodW = 15;
    localparam int CfgIdxW     = 2;
    localparam int CfgDataW    = 16;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BIT_PERIOD      = 2'd0,
        CFG_HALF_BIT_PERIOD = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] tx_data;
        logic       tx_request;
        logic       rx_level;
    } t_in_word;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       tx_busy;
        logic       tx_line;
    } t_out_word;

    typedef struct packed {
        logic                valid;
        logic [DataBits-1:0] data;
    } t_rx_status;

    typedef struct packed {
        logic line;
        logic busy;
    } t_tx_status;

endpackage

// ===== src/tuart_rx.sv =====
// Receiver: start edge hunt, mid-bit sampling and byte assembly.
module tuart_rx #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic                   i_level,
    input  logic [TICK_WIDTH-1:0]  i_period,
    input  logic [TICK_WIDTH-1:0]  i_half_period,
    output tuart_pkg::t_rx_status  o_next
);

    localparam int CntW = TICK_WIDTH + 1;

    logic                             r_sampling, n_sampling;
    logic                             r_prev_level, n_prev_level;
    logic [CntW-1:0]                  r_tick_count, n_tick_count;
    logic [tuart_pkg::BitCntW-1:0]    r_bits_left, n_bits_left;
    logic [tuart_pkg::DataBits-1:0]   r_shift, n_shift;
    logic [tuart_pkg::DataBits-1:0]   r_hold, n_hold;
    logic                             n_done;

    always_comb begin
        n_sampling   = r_sampling;
        n_tick_count = r_tick_count;
        n_bits_left  = r_bits_left;
        n_shift      = r_shift;
        n_hold       = r_hold;
        n_done       = 1'b0;
        n_prev_level = i_level;
        if (!r_sampling) begin
            // Only a true mark-to-space transition starts a frame.
            if (r_prev_level && !i_level) begin
                n_sampling   = 1'b1;
                n_tick_count = {1'b0, i_period} + {1'b0, i_half_period};
                n_bits_left  = tuart_pkg::BitCntW'(tuart_pkg::DataBits);
            end
        end else if (r_tick_count <= CntW'(1)) begin
            n_shift      = {i_level, r_shift[tuart_pkg::DataBits-1:1]};
            n_tick_count = CntW'(i_period);
            if (r_bits_left != '0) begin
                n_bits_left = r_bits_left - tuart_pkg::BitCntW'(1);
            end
            if (n_bits_left == '0) begin
                n_hold      = n_shift;
                n_bits_left = tuart_pkg::BitCntW'(tuart_pkg::DataBits);
                n_sampling  = 1'b0;
                n_done      = 1'b1;
            end
        end else begin
            n_tick_count = r_tick_count - CntW'(1);
        end
    end

    assign o_next.valid = n_done;
    assign o_next.data  = n_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sampling   <= 1'b0;
            r_prev_level <= 1'b1;
            r_tick_count <= '0;
            r_bits_left  <= tuart_pkg::BitCntW'(tuart_pkg::DataBits);
            r_shift      <= '0;
            r_hold       <= '0;
        end else if (i_step) begin
            r_sampling   <= n_sampling;
            r_prev_level <= n_prev_level;
            r_tick_count <= n_tick_count;
            r_bits_left  <= n_bits_left;
            r_shift      <= n_shift;
            r_hold       <= n_hold;
        end
    end

endmodule

// ===== src/tuart_tx.sv =====
// Transmitter: bit timer and frame shift register.
module tuart_tx #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_request,
    input  logic [7:0]              i_data,
    input  logic [TICK_WIDTH-1:0]   i_period,
    output tuart_pkg::t_tx_status   o_next
);

    localparam int FrameW = tuart_pkg::FrameBits;

    logic [TICK_WIDTH-1:0]          r_tick_count, n_tick_count;
    logic [FrameW-1:0]              r_shift, n_shift;
    logic [tuart_pkg::BitCntW-1:0]  r_bits_left, n_bits_left;
    logic                           r_active, n_active;
    logic                           r_next_level, n_next_level;
    logic                           r_level, n_level;

    always_comb begin
        n_tick_count = r_tick_count;
        n_shift      = r_shift;
        n_bits_left  = r_bits_left;
        n_active     = r_active;
        n_next_level = r_next_level;
        n_level      = r_level;
        if (r_active) begin
            if (r_tick_count <= TICK_WIDTH'(1)) begin
                // Bit boundary: drive the queued level and queue the next bit.
                n_tick_count = i_period;
                n_level      = r_next_level;
                if (r_bits_left == '0) begin
                    n_active    = 1'b0;
                    n_bits_left = tuart_pkg::BitCntW'(FrameW);
                end else begin
                    n_next_level = r_shift[0];
                    n_shift      = {1'b0, r_shift[FrameW-1:1]};
                    n_bits_left  = r_bits_left - tuart_pkg::BitCntW'(1);
                end
            end else begin
                n_tick_count = r_tick_count - TICK_WIDTH'(1);
            end
        end else if (i_request) begin
            // Stop bit, data LSB first, start bit in the low position.
            n_shift      = {1'b1, i_data[tuart_pkg::DataBits-1:0], 1'b0};
            n_bits_left  = tuart_pkg::BitCntW'(FrameW);
            n_tick_count = i_period;
            n_next_level = 1'b1;
            n_active     = 1'b1;
        end
    end

    assign o_next.line = n_level;
    assign o_next.busy = n_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_shift      <= '0;
            r_bits_left  <= tuart_pkg::BitCntW'(FrameW);
            r_active     <= 1'b0;
            r_next_level <= 1'b1;
            r_level      <= 1'b1;
        end else if (i_step) begin
            r_tick_count <= n_tick_count;
            r_shift      <= n_shift;
            r_bits_left  <= n_bits_left;
            r_active     <= n_active;
            r_next_level <= n_next_level;
            r_level      <= n_level;
        end
    end

endmodule

// ===== src/timer_based_uart_8n1.sv =====
// Top level of the tick-timed 8N1 UART: word pipeline, configuration and assertions.
// Throughput: one input word per clock cycle while downstream does not stall, set by the input and result registers.
// Path: an accepted word waits in the input register and then moves into the result register,
// provided the result register is free; downstream stall holds it in the input register.
// Reset (synchronous, active low) clears both pipeline stages, idles the receiver in
// edge hunt and the transmitter at mark, and loads bit_period 104 and half_bit_period 52.
module timer_based_uart_8n1 #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  tuart_pkg::t_in_word                   i_in_word,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output tuart_pkg::t_out_word                  o_out_word,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tuart_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [tuart_pkg::CfgDataW-1:0]        i_cfg_data
);

    // Configuration registers. Writes are always taken; an index outside
    // the register list is simply dropped.
    logic [tuart_pkg::BitPeriodW-1:0]  r_bit_period;
    logic [tuart_pkg::HalfPeriodW-1:0] r_half_period;
    logic                              cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period  <= tuart_pkg::BitPeriodW'(104);
            r_half_period <= tuart_pkg::HalfPeriodW'(52);
        end else if (cfg_write) begin
            if (i_cfg_index == tuart_pkg::CFG_BIT_PERIOD) begin
                r_bit_period <= i_cfg_data[tuart_pkg::BitPeriodW-1:0];
            end
            if (i_cfg_index == tuart_pkg::CFG_HALF_BIT_PERIOD) begin
                r_half_period <= i_cfg_data[tuart_pkg::HalfPeriodW-1:0];
            end
        end
    end

    // Timer loads are cut or widened to the tick counter width.
    logic [TICK_WIDTH-1:0] period_ticks;
    logic [TICK_WIDTH-1:0] half_ticks;

    assign period_ticks = TICK_WIDTH'(r_bit_period);
    assign half_ticks   = TICK_WIDTH'(r_half_period);

    // Two-stage word pipeline. The input register holds the tick that is being
    // worked on; the receiver and transmitter state advance exactly when that
    // word moves into the result register. The result register lets a new
    // word be taken while a finished one still waits downstream.
    logic                 r_in_valid;
    tuart_pkg::t_in_word  r_in;
    logic                 r_out_valid;
    tuart_pkg::t_out_word r_out;
    logic                 advance;

    tuart_pkg::t_rx_status rx_next;
    tuart_pkg::t_tx_status tx_next;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.rx_byte  <= rx_next.data;
            r_out.rx_valid <= rx_next.valid;
            r_out.tx_busy  <= tx_next.busy;
            r_out.tx_line  <= tx_next.line;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // The receiver samples the line level carried by each word.
    tuart_rx #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_level       (r_in.rx_level),
        .i_period      (period_ticks),
        .i_half_period (half_ticks),
        .o_next        (rx_next)
    );

    // The transmitter only looks at a request while it is idle.
    tuart_tx #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_tx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_request (r_in.tx_request),
        .i_data    (r_in.tx_data),
        .i_period  (period_ticks),
        .o_next    (tx_next)
    );

    // A word held in the input stage must not be lost or overwritten.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("input stage lost or changed a held word");

    // Upstream is only stalled when the input stage is full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input stage");

    // With no frame in flight the transmit line rests at mark.
    a_tx_idle_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.tx_busy |-> o_out_word.tx_line)
        else $error("transmit line at space while idle");

    // A completed byte is followed by at least one result without completion.
    a_rx_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && rx_next.valid |=> !(advance && rx_next.valid))
        else $error("receiver completed bytes on consecutive words");

endmodule
